/* rtl/core/ptc_pkg.sv */
package ptc_pkg;

	localparam int TEMP_W  = 12;
	localparam int SP_W    = 8;
	localparam int GAIN_W  = 16;
	localparam int ERR_W   = 12;
	localparam int INTEG_W = 16;
	localparam int E10_W   = 16;
	localparam int D100_W  = 20;
	localparam int PI_W    = 32;
	localparam int PD_W    = 36;
	localparam int SUM_W   = 37;
	localparam int DRV_W   = 8;
	localparam int SPD_W   = 7;

	localparam logic signed [ERR_W:0]     ERR_MAX     = 13'sd2047;
	localparam logic signed [ERR_W:0]     ERR_MIN     = -13'sd2048;
	localparam logic signed [INTEG_W:0]   INTEG_LIMIT = 17'sd20000;
	localparam logic        [SUM_W-1:0]   SAT_MAG     = 37'd2560000;
	localparam logic        [12:0]        RECIP_25    = 13'd5243;
	localparam logic        [SPD_W-1:0]   OUT_LIMIT   = 7'd100;

	localparam logic signed [SP_W-1:0]    SP_RESET = 8'sd30;
	localparam logic signed [GAIN_W-1:0]  KP_RESET = 16'sd2560;
	localparam logic signed [GAIN_W-1:0]  KI_RESET = 16'sd26;
	localparam logic signed [GAIN_W-1:0]  KD_RESET = 16'sd1280;

	typedef enum logic [1:0] {
		REG_SETPOINT = 2'd0,
		REG_KP       = 2'd1,
		REG_KI       = 2'd2,
		REG_KD       = 2'd3
	} ptc_reg_t;

	typedef struct packed {
		logic signed [GAIN_W-1:0] kp;
		logic signed [GAIN_W-1:0] ki;
		logic signed [GAIN_W-1:0] kd;
	} ptc_gain_t;

	typedef struct packed {
		logic                     upd;
		logic signed [ERR_W-1:0]  err;
		logic signed [E10_W-1:0]  err_x10;
		logic signed [INTEG_W-1:0] integ;
		logic signed [D100_W-1:0] diff_x100;
	} ptc_err_t;

	typedef struct packed {
		logic                    upd;
		logic signed [ERR_W-1:0] err;
		logic signed [PI_W-1:0]  p_term;
		logic signed [PI_W-1:0]  i_term;
		logic signed [PD_W-1:0]  d_term;
	} ptc_prod_t;

endpackage

/* rtl/core/pid_temperature_controller.sv */
// Pipeline: input register, then error, multiply, sum and output stages. Throughput:
// one item per cycle unless m_axis_tready stalls; integral and previous-error feedback
// closes within the error stage, so consecutive samples never wait on each other.
// Reset: clears all pipeline valids, integral and previous error, loads default
// setpoint and gains, and sets the held drive state to heater on, fan off.
module pid_temperature_controller import ptc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [11:0] temperature_tenths
	input  logic [1:0]  s_axis_tuser,  // [0] command, [1] sample_valid
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [11:0] error_tenths, [19:12] drive_output,
	                                   // [20] heater_on, [21] fan_on, [28:22] fan_speed
	output logic [0:0]  m_axis_tuser,  // [0] updated
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic                     valid_s1;
	logic                     cmd_s1;
	logic signed [TEMP_W-1:0] temp_s1;
	logic                     smpl_s1;

	logic signed [SP_W-1:0]   setpoint_q;
	ptc_gain_t                gains_q;
	logic                     cfg_fire;
	logic                     sp_clear;

	logic      front_ready;
	logic      err_valid;
	logic      err_ready;
	ptc_err_t  err_data;
	logic      prod_valid;
	logic      prod_ready;
	ptc_prod_t prod_data;

	logic                    res_upd;
	logic signed [ERR_W-1:0] res_err;
	logic signed [DRV_W-1:0] res_drive;
	logic                    res_heater;
	logic                    res_fan;
	logic [SPD_W-1:0]        res_speed;

	assign cfg_ready     = 1'b1;
	assign cfg_fire      = cfg_valid && cfg_ready;
	assign sp_clear      = cfg_fire && (ptc_reg_t'(cfg_index) == REG_SETPOINT);
	assign s_axis_tready = !valid_s1 || front_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q <= SP_RESET;
			gains_q.kp <= KP_RESET;
			gains_q.ki <= KI_RESET;
			gains_q.kd <= KD_RESET;
		end else if (cfg_fire) begin
			unique case (ptc_reg_t'(cfg_index))
				REG_SETPOINT: setpoint_q <= cfg_data[SP_W-1:0];
				REG_KP:       gains_q.kp <= cfg_data;
				REG_KI:       gains_q.ki <= cfg_data;
				REG_KD:       gains_q.kd <= cfg_data;
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			cmd_s1  <= s_axis_tuser[0];
			smpl_s1 <= s_axis_tuser[1];
			temp_s1 <= s_axis_tdata[TEMP_W-1:0];
		end
	end

	ptc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (sp_clear),
		.setpoint  (setpoint_q),
		.in_valid  (valid_s1),
		.in_ready  (front_ready),
		.in_cmd    (cmd_s1),
		.in_temp   (temp_s1),
		.in_smpl   (smpl_s1),
		.out_valid (err_valid),
		.out_ready (err_ready),
		.out_data  (err_data)
	);

	ptc_mult u_mult (
		.clk       (clk),
		.arst_n    (arst_n),
		.gains     (gains_q),
		.in_valid  (err_valid),
		.in_ready  (err_ready),
		.in_data   (err_data),
		.out_valid (prod_valid),
		.out_ready (prod_ready),
		.out_data  (prod_data)
	);

	ptc_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (prod_valid),
		.in_ready   (prod_ready),
		.in_data    (prod_data),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_upd    (res_upd),
		.out_err    (res_err),
		.out_drive  (res_drive),
		.out_heater (res_heater),
		.out_fan    (res_fan),
		.out_speed  (res_speed)
	);

	assign m_axis_tuser = res_upd;
	assign m_axis_tdata = {3'b000, res_speed, res_fan, res_heater, res_drive, res_err};

endmodule

/* rtl/core/ptc_front.sv */
module ptc_front import ptc_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    clear,
	input  logic signed [SP_W-1:0]  setpoint,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    in_cmd,
	input  logic signed [TEMP_W-1:0] in_temp,
	input  logic                    in_smpl,
	output logic                    out_valid,
	input  logic                    out_ready,
	output ptc_err_t                out_data
);

	logic                      valid_s2;
	ptc_err_t                  data_s2;
	logic signed [INTEG_W-1:0] integ_q;
	logic signed [ERR_W-1:0]   prev_q;

	logic signed [ERR_W-1:0]   sp10;
	logic signed [ERR_W:0]     raw_err;
	logic signed [ERR_W-1:0]   err;
	logic signed [INTEG_W:0]   integ_raw;
	logic signed [INTEG_W-1:0] integ_next;
	logic signed [ERR_W:0]     diff;
	logic                      fire;
	logic                      upd;

	assign fire     = in_valid && in_ready;
	assign in_ready = !valid_s2 || out_ready;
	assign upd      = !in_cmd && in_smpl;

	always_comb begin
		sp10    = (ERR_W'(setpoint) <<< 3) + (ERR_W'(setpoint) <<< 1);
		raw_err = (ERR_W+1)'(sp10) - (ERR_W+1)'(in_temp);
		if (raw_err > ERR_MAX) begin
			err = ERR_MAX[ERR_W-1:0];
		end else if (raw_err < ERR_MIN) begin
			err = ERR_MIN[ERR_W-1:0];
		end else begin
			err = raw_err[ERR_W-1:0];
		end
		integ_raw = (INTEG_W+1)'(integ_q) + (INTEG_W+1)'(err);
		if (integ_raw > INTEG_LIMIT) begin
			integ_next = INTEG_LIMIT[INTEG_W-1:0];
		end else if (integ_raw < -INTEG_LIMIT) begin
			integ_next = INTEG_W'(-INTEG_LIMIT);
		end else begin
			integ_next = integ_raw[INTEG_W-1:0];
		end
		diff = (ERR_W+1)'(err) - (ERR_W+1)'(prev_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q  <= '0;
			prev_q   <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (clear) begin
				integ_q <= '0;
				prev_q  <= '0;
			end else if (fire && in_cmd) begin
				integ_q <= '0;
				prev_q  <= '0;
			end else if (fire && upd) begin
				integ_q <= integ_next;
				prev_q  <= err;
			end
			if (in_ready) begin
				valid_s2 <= in_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			data_s2.upd       <= upd;
			data_s2.err       <= err;
			data_s2.err_x10   <= (E10_W'(err) <<< 3) + (E10_W'(err) <<< 1);
			data_s2.integ     <= integ_next;
			data_s2.diff_x100 <= (D100_W'(diff) <<< 6) + (D100_W'(diff) <<< 5)
				+ (D100_W'(diff) <<< 2);
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

endmodule

/* rtl/core/ptc_mult.sv */
module ptc_mult import ptc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  ptc_gain_t gains,
	input  logic      in_valid,
	output logic      in_ready,
	input  ptc_err_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output ptc_prod_t out_data
);

	logic      valid_s3;
	ptc_prod_t data_s3;

	assign in_ready = !valid_s3 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s3.upd    <= in_data.upd;
			data_s3.err    <= in_data.err;
			data_s3.p_term <= PI_W'(gains.kp) * PI_W'(in_data.err_x10);
			data_s3.i_term <= PI_W'(gains.ki) * PI_W'(in_data.integ);
			data_s3.d_term <= PD_W'(gains.kd) * PD_W'(in_data.diff_x100);
		end
	end

	assign out_valid = valid_s3;
	assign out_data  = data_s3;

endmodule

/* rtl/core/ptc_out.sv */
module ptc_out import ptc_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  ptc_prod_t               in_data,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    out_upd,
	output logic signed [ERR_W-1:0] out_err,
	output logic signed [DRV_W-1:0] out_drive,
	output logic                    out_heater,
	output logic                    out_fan,
	output logic [SPD_W-1:0]        out_speed
);

	logic                    valid_s4;
	logic                    upd_s4;
	logic signed [ERR_W-1:0] err_s4;
	logic signed [SUM_W-1:0] sum_s4;

	logic                    valid_q;
	logic                    upd_q;
	logic signed [ERR_W-1:0] err_q;
	logic signed [DRV_W-1:0] drive_q;
	logic                    heater_q;
	logic                    fan_q;
	logic [SPD_W-1:0]        speed_q;

	logic                    s4_ready;
	logic                    neg;
	logic                    pos;
	logic [SUM_W-1:0]        mag;
	logic [24:0]             scaled;
	logic [SPD_W-1:0]        quot;
	logic signed [DRV_W-1:0] drive;

	assign s4_ready = !valid_q || out_ready;
	assign in_ready = !valid_s4 || s4_ready;

	// |S| / 25600 = (|S| >> 10) / 25, reciprocal exact below 2500
	always_comb begin
		neg    = sum_s4[SUM_W-1];
		pos    = !neg && (|sum_s4);
		mag    = neg ? SUM_W'(-sum_s4) : SUM_W'(sum_s4);
		scaled = 25'(mag[21:10]) * 25'(RECIP_25);
		quot   = (mag >= SAT_MAG) ? OUT_LIMIT : scaled[23:17];
		drive  = neg ? -DRV_W'(quot) : DRV_W'(quot);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_q  <= 1'b0;
			upd_q    <= 1'b0;
			err_q    <= '0;
			drive_q  <= '0;
			heater_q <= 1'b1;
			fan_q    <= 1'b0;
			speed_q  <= '0;
		end else begin
			if (in_ready) begin
				valid_s4 <= in_valid;
			end
			if (s4_ready) begin
				valid_q <= valid_s4;
			end
			if (valid_s4 && s4_ready) begin
				upd_q <= upd_s4;
				if (upd_s4) begin
					err_q    <= err_s4;
					drive_q  <= drive;
					heater_q <= pos;
					fan_q    <= neg;
					speed_q  <= neg ? quot : '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			upd_s4 <= in_data.upd;
			err_s4 <= in_data.err;
			sum_s4 <= SUM_W'(in_data.p_term) + SUM_W'(in_data.i_term)
				+ SUM_W'(in_data.d_term);
		end
	end

	assign out_valid  = valid_q;
	assign out_upd    = upd_q;
	assign out_err    = err_q;
	assign out_drive  = drive_q;
	assign out_heater = heater_q;
	assign out_fan    = fan_q;
	assign out_speed  = speed_q;

endmodule
